// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the patch evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/bbp_pkg.sv =====
// Shared constants, types and helpers of the bicubic patch evaluator.
package bbp_pkg;

  localparam int MAX_RESOLUTION = 256;
  localparam int CONTROL_POINTS = 16;
  localparam int AXES           = 3;
  localparam int COORD_W        = 32;
  localparam int RES_W          = 9;
  localparam int STEP_W         = $clog2(MAX_RESOLUTION);
  localparam int SLOT_W         = $clog2(CONTROL_POINTS);
  localparam int CNT_W          = SLOT_W + 1;
  localparam int STORE_W        = AXES * COORD_W;
  localparam int T_DIV_STEPS    = STEP_W + 16;
  localparam int ROOT_STEPS     = 31;
  localparam int TAN_DIV_STEPS  = 15;

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(16);
  localparam logic [RES_W-1:0] RES_MIN   = RES_W'(2);
  localparam logic [RES_W-1:0] RES_MAX   = RES_W'(MAX_RESOLUTION);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef logic [30:0]        bw_t;
  typedef logic signed [31:0] dw_t;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [63:0] acc_t;
  typedef logic signed [15:0] tan_t;
  typedef logic [STEP_W-1:0]  step_t;

  typedef struct packed {
    logic  start;
    step_t d;
    step_t step_u;
    step_t step_v;
  } wgt_req_t;

  typedef enum logic [2:0] {ST_IDLE, ST_WGT, ST_ACC, ST_NRM, ST_OUT} top_state_t;
  typedef enum logic [1:0] {W_IDLE, W_DIV, W_PROD, W_BERN} wgt_state_t;
  typedef enum logic [2:0] {
    N_IDLE, N_LOAD, N_SHIFT, N_SQ, N_ROOT, N_DSET, N_DIV, N_STORE
  } nrm_state_t;

  function automatic logic [63:0] mag64(input acc_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

// ===== rtl/bbp_ifs.sv =====
// Valid/ready channel interfaces for the evaluator's request and response.
interface bbp_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         point_slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [7:0]         u_step;
  logic [7:0]         v_step;
  modport source(output valid, kind, point_slot, coord_x, coord_y, coord_z, u_step,
                 v_step, input ready);
  modport sink(input valid, kind, point_slot, coord_x, coord_y, coord_z, u_step,
               v_step, output ready);
endinterface

interface bbp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] tan_u_x;
  logic signed [15:0] tan_u_y;
  logic signed [15:0] tan_u_z;
  logic signed [15:0] tan_v_x;
  logic signed [15:0] tan_v_y;
  logic signed [15:0] tan_v_z;
  logic [1:0]         degenerate;
  modport source(output valid, point_x, point_y, point_z, tan_u_x, tan_u_y, tan_u_z,
                 tan_v_x, tan_v_y, tan_v_z, degenerate, input ready);
  modport sink(input valid, point_x, point_y, point_z, tan_u_x, tan_u_y, tan_u_z,
               tan_v_x, tan_v_y, tan_v_z, degenerate, output ready);
endinterface

// ===== rtl/bbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bbp_wgt.sv =====
// Grid parameter divider and cubic Bernstein weight and derivative generator for both directions.
module bbp_wgt import bbp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  wgt_req_t      req,
  output logic          done,
  output bw_t   [3:0]   bu,
  output bw_t   [3:0]   bv,
  output dw_t   [3:0]   du,
  output dw_t   [3:0]   dv
);

  wgt_state_t state, state_next;

  logic        axis;
  step_t       d;
  step_t       step_v;
  logic [23:0] num;
  logic [7:0]  rem;
  logic [4:0]  cnt;
  logic [16:0] t, w;
  logic [33:0] w2, tw, t2;

  logic [8:0]  cand;
  logic        fits;
  logic [16:0] w_c;
  logic [51:0] p0, p1, p2, p3;
  logic [51:0] r0, r1, r2, r3;
  logic signed [35:0] w2s3, tw6, t2s3;
  bw_t [3:0]   b_c;
  dw_t [3:0]   d_c;

  function automatic logic [23:0] div_init(input step_t s, input step_t dd);
    step_t sv;
    sv = (s > dd) ? dd : s;
    return {sv, 16'd0} + 24'(dd >> 1);
  endfunction

  function automatic dw_t rnd4(input logic signed [35:0] x);
    logic [35:0] mg, m;
    mg = x[35] ? 36'(-x) : 36'(x);
    m  = (mg + 36'd8) >> 4;
    return x[35] ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  always_comb begin
    cand = {rem, num[23]};
    fits = (cand >= {1'b0, d});
    w_c  = 17'h10000 - num[16:0];

    p0 = 52'(w2) * 52'(w);
    p1 = 52'(tw) * 52'(w);
    p2 = 52'(t2) * 52'(w);
    p3 = 52'(t2) * 52'(t);
    r0 = p0;
    r1 = p1 + {p1[50:0], 1'b0};
    r2 = p2 + {p2[50:0], 1'b0};
    r3 = p3;
    b_c[0] = 31'((r0 + 52'h20000) >> 18);
    b_c[1] = 31'((r1 + 52'h20000) >> 18);
    b_c[2] = 31'((r2 + 52'h20000) >> 18);
    b_c[3] = 31'((r3 + 52'h20000) >> 18);

    w2s3 = $signed({2'b0, w2}) + $signed({1'b0, w2, 1'b0});
    tw6  = $signed({1'b0, tw, 1'b0}) + $signed({tw, 2'b0});
    t2s3 = $signed({2'b0, t2}) + $signed({1'b0, t2, 1'b0});
    d_c[0] = rnd4(-w2s3);
    d_c[1] = rnd4(w2s3 - tw6);
    d_c[2] = rnd4(tw6 - t2s3);
    d_c[3] = rnd4(t2s3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      W_IDLE: begin
        if (req.start) state_next = W_DIV;
      end
      W_DIV: begin
        if (cnt == 5'(T_DIV_STEPS - 1)) state_next = W_PROD;
      end
      W_PROD: state_next = W_BERN;
      W_BERN: begin
        if (axis) begin
          state_next = W_IDLE;
          done       = 1'b1;
        end else begin
          state_next = W_DIV;
        end
      end
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (req.start) begin
          axis   <= 1'b0;
          d      <= req.d;
          step_v <= req.step_v;
          num    <= div_init(req.step_u, req.d);
          rem    <= '0;
          cnt    <= '0;
        end
      end
      W_DIV: begin
        num <= {num[22:0], fits};
        rem <= fits ? 8'(cand - {1'b0, d}) : cand[7:0];
        cnt <= cnt + 5'd1;
      end
      W_PROD: begin
        t  <= num[16:0];
        w  <= w_c;
        w2 <= 34'(w_c) * 34'(w_c);
        tw <= 34'(num[16:0]) * 34'(w_c);
        t2 <= 34'(num[16:0]) * 34'(num[16:0]);
      end
      W_BERN: begin
        if (!axis) begin
          bu   <= b_c;
          du   <= d_c;
          axis <= 1'b1;
          num  <= div_init(step_v, d);
          rem  <= '0;
          cnt  <= '0;
        end else begin
          bv <= b_c;
          dv <= d_c;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/bbp_mac.sv =====
// Weight product, rounding and multiply-accumulate lanes for point and tangents.
module bbp_mac import bbp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           in_valid,
  input  coord_t [2:0]   c,
  input  bw_t            bu_i,
  input  bw_t            bv_j,
  input  dw_t            du_i,
  input  dw_t            dv_j,
  output logic           idle,
  output acc_t   [2:0]   acc_p,
  output acc_t   [2:0]   acc_u,
  output acc_t   [2:0]   acc_v
);

  logic         v1, v2, v3;
  logic [61:0]  pp;
  acc_t         pu, pv;
  coord_t [2:0] c1, c2;
  dw_t          wp, wu, wv;
  acc_t   [2:0] mp, mu, mv;

  function automatic dw_t rnd30(input acc_t x);
    logic [63:0] m;
    m = (mag64(x) + 64'h2000_0000) >> 30;
    return x[63] ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  assign idle = !(in_valid || v1 || v2 || v3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    pp <= 62'(bu_i) * 62'(bv_j);
    pu <= acc_t'(du_i) * acc_t'($signed({1'b0, bv_j}));
    pv <= acc_t'($signed({1'b0, bu_i})) * acc_t'(dv_j);
    c1 <= c;

    wp <= $signed(32'((pp + 62'h2000_0000) >> 30));
    wu <= rnd30(pu);
    wv <= rnd30(pv);
    c2 <= c1;

    for (int a = 0; a < AXES; a++) begin
      mp[a] <= acc_t'(c2[a]) * acc_t'(wp);
      mu[a] <= acc_t'(c2[a]) * acc_t'(wu);
      mv[a] <= acc_t'(c2[a]) * acc_t'(wv);
    end

    for (int a = 0; a < AXES; a++) begin
      if (clear) begin
        acc_p[a] <= '0;
        acc_u[a] <= '0;
        acc_v[a] <= '0;
      end else if (v3) begin
        acc_p[a] <= acc_p[a] + mp[a];
        acc_u[a] <= acc_u[a] + mu[a];
        acc_v[a] <= acc_v[a] + mv[a];
      end
    end
  end

endmodule

// ===== rtl/bbp_nrm.sv =====
// Point rounding and saturation, and tangent normalisation by bit-serial root and divide.
module bbp_nrm import bbp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  acc_t   [2:0]   acc_p,
  input  acc_t   [2:0]   acc_u,
  input  acc_t   [2:0]   acc_v,
  output logic           done,
  output coord_t [2:0]   point,
  output tan_t   [2:0]   tan_u,
  output tan_t   [2:0]   tan_v,
  output logic   [1:0]   deg
);

  nrm_state_t state, state_next;

  logic              axis;
  logic [63:0]       m [AXES];
  logic [2:0]        neg;
  logic [61:0]       rad;
  logic [31:0]       rem;
  logic [30:0]       root;
  logic [4:0]        cnt;
  logic [30:0]       dr [AXES];
  logic [14:0]       dq [AXES];

  acc_t [2:0]        vec;
  logic              vzero;
  logic              big;
  logic [59:0]       sq_term;
  logic [33:0]       rem_sh, trial;
  logic              root_ge;

  function automatic coord_t sat_pt(input acc_t x);
    logic [63:0] mr;
    acc_t        p;
    mr = (mag64(x) + 64'h2000_0000) >> 30;
    p  = x[63] ? -$signed(mr) : $signed(mr);
    if (p > acc_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (p < acc_t'(-64'sh8000_0000)) return 32'sh8000_0000;
    return p[31:0];
  endfunction

  always_comb begin
    vec     = axis ? acc_v : acc_u;
    vzero   = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
    big     = (m[0][63:30] != '0) || (m[1][63:30] != '0) || (m[2][63:30] != '0);
    sq_term = 60'(m[cnt[1:0]][29:0]) * 60'(m[cnt[1:0]][29:0]);
    rem_sh  = {rem, rad[61:60]};
    trial   = {1'b0, root, 2'b01};
    root_ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      N_IDLE: begin
        if (start) state_next = N_LOAD;
      end
      N_LOAD: begin
        if (!vzero) begin
          state_next = N_SHIFT;
        end else if (axis) begin
          state_next = N_IDLE;
          done       = 1'b1;
        end
      end
      N_SHIFT: begin
        if (!big) state_next = N_SQ;
      end
      N_SQ: begin
        if (cnt == 5'(AXES - 1)) state_next = N_ROOT;
      end
      N_ROOT: begin
        if (cnt == 5'(ROOT_STEPS - 1)) state_next = N_DSET;
      end
      N_DSET: state_next = N_DIV;
      N_DIV: begin
        if (cnt == 5'(TAN_DIV_STEPS - 1)) state_next = N_STORE;
      end
      N_STORE: begin
        if (axis) begin
          state_next = N_IDLE;
          done       = 1'b1;
        end else begin
          state_next = N_LOAD;
        end
      end
      default: state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          axis <= 1'b0;
          deg  <= '0;
          for (int a = 0; a < AXES; a++) point[a] <= sat_pt(acc_p[a]);
        end
      end
      N_LOAD: begin
        for (int a = 0; a < AXES; a++) begin
          m[a]   <= mag64(vec[a]);
          neg[a] <= vec[a][63];
        end
        if (vzero) begin
          // A tangent that sums to zero is reported as zero and flagged.
          deg[axis] <= 1'b1;
          if (axis) tan_v <= '0;
          else      tan_u <= '0;
          axis <= 1'b1;
        end
      end
      N_SHIFT: begin
        if (big) begin
          for (int a = 0; a < AXES; a++) m[a] <= m[a] >> 1;
        end else begin
          rad <= '0;
          cnt <= '0;
        end
      end
      N_SQ: begin
        rad <= rad + 62'(sq_term);
        cnt <= (cnt == 5'(AXES - 1)) ? 5'd0 : cnt + 5'd1;
        if (cnt == 5'(AXES - 1)) begin
          rem  <= '0;
          root <= '0;
        end
      end
      N_ROOT: begin
        rem  <= 32'(root_ge ? rem_sh - trial : rem_sh);
        root <= {root[29:0], root_ge};
        rad  <= {rad[59:0], 2'b00};
        cnt  <= cnt + 5'd1;
      end
      N_DSET: begin
        // The quotient never exceeds 15 bits, so the top of the dividend
        // already lies below the divisor.
        for (int a = 0; a < AXES; a++) begin
          dr[a] <= 31'((45'({m[a][29:0], 14'd0}) + 45'(root[30:1])) >> 15);
          dq[a] <= 15'({m[a][29:0], 14'd0} + 44'(root[30:1]));
        end
        cnt <= '0;
      end
      N_DIV: begin
        for (int a = 0; a < AXES; a++) begin
          if ({dr[a], dq[a][14]} >= {1'b0, root}) begin
            dr[a] <= 31'({dr[a], dq[a][14]} - {1'b0, root});
            dq[a] <= {dq[a][13:0], 1'b1};
          end else begin
            dr[a] <= 31'({dr[a], dq[a][14]});
            dq[a] <= {dq[a][13:0], 1'b0};
          end
        end
        cnt <= cnt + 5'd1;
      end
      N_STORE: begin
        for (int a = 0; a < AXES; a++) begin
          if (axis) tan_v[a] <= neg[a] ? -$signed({1'b0, dq[a]}) : $signed({1'b0, dq[a]});
          else      tan_u[a] <= neg[a] ? -$signed({1'b0, dq[a]}) : $signed({1'b0, dq[a]});
        end
        axis <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/bicubic_bezier_patch_eval.sv =====
// A load transaction is written in the cycle it is taken; one load per cycle while idle.
// An evaluate transaction runs the bit-serial grid divider and weights, then the
// 16-read store sweep and its pipeline, then normalisation with its shift steps,
// whose root and divide are skipped for a tangent that sums to zero. The next
// transaction can be taken the cycle after the output is loaded, while the result waits.
// Reset (synchronous, rst high): resolution 16, output empty; the store is not cleared.
`include "assert_macros.svh"

module bicubic_bezier_patch_eval import bbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [RES_W-1:0] wr_data,
  bbp_in_if.sink           req,
  bbp_out_if.source        rsp
);

  top_state_t state, state_next;

  logic [RES_W-1:0] res;
  logic [RES_W-1:0] res_c;
  step_t            d;
  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  logic             accept;
  logic             out_load;

  wgt_req_t         wreq;
  logic             wgt_done;
  bw_t [3:0]        bu, bv;
  dw_t [3:0]        du, dv;

  logic [STORE_W-1:0] rdata;
  coord_t [2:0]     c;

  logic             mac_clear;
  logic             mac_idle;
  acc_t [2:0]       acc_p, acc_u, acc_v;

  logic             nrm_start;
  logic             nrm_done;
  coord_t [2:0]     pt;
  tan_t [2:0]       tu, tv;
  logic [1:0]       deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= RES_RESET;
    end else if (wr_en) begin
      res <= wr_data;
    end
  end

  always_comb begin
    if (res < RES_MIN)      res_c = RES_MIN;
    else if (res > RES_MAX) res_c = RES_MAX;
    else                    res_c = res;
    d = STEP_W'(res_c - RES_W'(1));
  end

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == ST_OUT) && (!rsp.valid || rsp.ready);

  assign wreq.start  = accept && (req.kind == KIND_EVAL);
  assign wreq.d      = d;
  assign wreq.step_u = req.u_step;
  assign wreq.step_v = req.v_step;

  assign mac_clear = (state == ST_WGT) && wgt_done;
  assign nrm_start = (state == ST_ACC) && cnt[SLOT_W] && mac_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.kind == KIND_EVAL)) state_next = ST_WGT;
      end
      ST_WGT: begin
        if (wgt_done) state_next = ST_ACC;
      end
      ST_ACC: begin
        if (nrm_start) state_next = ST_NRM;
      end
      ST_NRM: begin
        if (nrm_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store sweep: one control point read per cycle, weights picked by its row and column.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      rd_vld <= (state == ST_ACC) && !cnt[SLOT_W];
      if (state == ST_WGT) begin
        cnt <= '0;
      end else if ((state == ST_ACC) && !cnt[SLOT_W]) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[SLOT_W-1:0];
  end

  assign c[0] = rdata[COORD_W-1:0];
  assign c[1] = rdata[2*COORD_W-1:COORD_W];
  assign c[2] = rdata[3*COORD_W-1:2*COORD_W];

  bbp_ram #(
    .WIDTH (STORE_W),
    .DEPTH (CONTROL_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (accept && (req.kind == KIND_LOAD)),
    .waddr (req.point_slot),
    .wdata ({req.coord_z, req.coord_y, req.coord_x}),
    .raddr (cnt[SLOT_W-1:0]),
    .rdata (rdata)
  );

  bbp_wgt u_wgt (
    .clk  (clk),
    .rst  (rst),
    .req  (wreq),
    .done (wgt_done),
    .bu   (bu),
    .bv   (bv),
    .du   (du),
    .dv   (dv)
  );

  bbp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .clear    (mac_clear),
    .in_valid (rd_vld),
    .c        (c),
    .bu_i     (bu[rd_idx[3:2]]),
    .bv_j     (bv[rd_idx[1:0]]),
    .du_i     (du[rd_idx[3:2]]),
    .dv_j     (dv[rd_idx[1:0]]),
    .idle     (mac_idle),
    .acc_p    (acc_p),
    .acc_u    (acc_u),
    .acc_v    (acc_v)
  );

  bbp_nrm u_nrm (
    .clk   (clk),
    .rst   (rst),
    .start (nrm_start),
    .acc_p (acc_p),
    .acc_u (acc_u),
    .acc_v (acc_v),
    .done  (nrm_done),
    .point (pt),
    .tan_u (tu),
    .tan_v (tv),
    .deg   (deg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.point_x    <= pt[0];
      rsp.point_y    <= pt[1];
      rsp.point_z    <= pt[2];
      rsp.tan_u_x    <= tu[0];
      rsp.tan_u_y    <= tu[1];
      rsp.tan_u_z    <= tu[2];
      rsp.tan_v_x    <= tv[0];
      rsp.tan_v_y    <= tv[1];
      rsp.tan_v_z    <= tv[2];
      rsp.degenerate <= deg;
    end
  end

  `CHK_IMPL(a_mac_quiet, (state != ST_ACC) && (state != ST_NRM), mac_idle)
  `CHK_IMPL(a_wgt_done_in_wgt, wgt_done, state == ST_WGT)
  `CHK_NEXT(a_out_load, out_load, rsp.valid && (state == ST_IDLE))

endmodule
